/* design/assert_macros.svh */
// Assertion macros shared by the design files.
// Clocked on aclk; the reset form is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* design/dsl_pkg.sv */
// Package for the delimited span locator: search phases, status codes,
// register indexes and default sizes. No dependencies.
package dsl_pkg;

    localparam int KEYWORD_BYTES_DEF = 8;
    localparam int OFFSET_BITS_DEF   = 32;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_INDEX_W       = 2;
    localparam int OUT_FIELD_W       = 32;

    typedef enum logic [1:0] {
        PH_SEEK_START = 2'd0,
        PH_SEEK_END   = 2'd1,
        PH_DONE       = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_FOUND         = 2'd0,
        ST_START_MISSING = 2'd1,
        ST_END_MISSING   = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_PATTERN = 2'd0,
        REG_START_LENGTH  = 2'd1,
        REG_END_PATTERN   = 2'd2,
        REG_END_LENGTH    = 2'd3
    } reg_index_t;

endpackage

/* design/delimited_span_locator.sv */
// Delimited span locator: finds start and end keywords in a byte stream.
// Depends on dsl_pkg and assert_macros.svh.
//
//  channel   | beat                     | fields (lowest bit first)
//  ----------+--------------------------+-----------------------------------
//  s_        | one stream byte          | tdata: data_byte; tlast: last_byte
//  m_        | at most one per stream   | tdata: span_offset, span_length;
//            |                          | tuser: status
//  cfg_wr_   | one register write       | index, data
//
// One byte per cycle while s_tready is high: the window compare, position count and length subtract
// sit between the search registers and the result register.
// A result appears on m_ the cycle after the byte beat that caused it.
// s_tready drops only while a result is held and m_tready is low.
// aresetn clears search state and registers; a tlast beat clears the search.
`include "assert_macros.svh"

module delimited_span_locator #(
    parameter int KEYWORD_BYTES = dsl_pkg::KEYWORD_BYTES_DEF,
    parameter int OFFSET_BITS   = dsl_pkg::OFFSET_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [dsl_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [dsl_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // data_byte
    input  logic                            s_tlast,   // last_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [63:0]                     m_tdata,   // span_offset, span_length
    output logic [1:0]                      m_tuser    // status
);
    import dsl_pkg::*;

    localparam int KCW = $clog2(KEYWORD_BYTES + 1);

    logic [CFG_DATA_W-1:0] start_pat_reg, end_pat_reg;
    logic [3:0]            start_len_reg, end_len_reg;

    logic [7:0]             win_reg [KEYWORD_BYTES];
    logic [7:0]             win_next[KEYWORD_BYTES];
    logic [KCW-1:0]         seen_reg, seen_next;
    logic [KCW-1:0]         after_reg, after_next;
    phase_t                 phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] found_reg, found_next;

    logic                   out_valid_reg;
    logic [1:0]             out_status_reg;
    logic [OUT_FIELD_W-1:0] out_off_reg, out_len_reg;

    logic [KCW-1:0]         ls, le;
    logic [KEYWORD_BYTES:0] start_hit, end_hit;
    logic [OFFSET_BITS-1:0] npos, span_gap;
    logic                   res_valid;
    status_t                res_status;
    logic [OFFSET_BITS-1:0] res_off, res_len;
    logic [OUT_FIELD_W-1:0] res_off_c, res_len_c;
    logic                   accept;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;

    assign ls = (start_len_reg > 4'(KEYWORD_BYTES)) ? KCW'(KEYWORD_BYTES)
                                                     : KCW'(start_len_reg);
    assign le = (end_len_reg > 4'(KEYWORD_BYTES)) ? KCW'(KEYWORD_BYTES)
                                                   : KCW'(end_len_reg);

    always_comb begin
        win_next[0] = s_tdata;
        for (int k = 1; k < KEYWORD_BYTES; k++) begin
            win_next[k] = win_reg[k-1];
        end
    end

    // hit[L]: newest L bytes equal the first L keyword bytes, oldest first
    always_comb begin
        start_hit = '1;
        end_hit   = '1;
        for (int l = 1; l <= KEYWORD_BYTES; l++) begin
            for (int i = 0; i < l; i++) begin
                if (win_next[l-1-i] != start_pat_reg[8*i +: 8]) begin
                    start_hit[l] = 1'b0;
                end
                if (win_next[l-1-i] != end_pat_reg[8*i +: 8]) begin
                    end_hit[l] = 1'b0;
                end
            end
        end
    end

    assign npos = (pos_reg == '1) ? pos_reg : pos_reg + OFFSET_BITS'(1);

    always_comb begin
        phase_next = phase_reg;
        found_next = found_reg;
        after_next = after_reg;
        res_valid  = 1'b0;
        res_status = ST_FOUND;
        res_off    = '0;
        res_len    = '0;
        span_gap   = npos - found_reg;

        if (phase_next == PH_SEEK_START && ls == '0) begin
            found_next = pos_reg;
            after_next = '0;
            phase_next = PH_SEEK_END;
        end
        if (phase_next == PH_SEEK_END && le == '0) begin
            res_valid  = 1'b1;
            res_off    = found_next;
            phase_next = PH_DONE;
        end

        seen_next = (seen_reg < KCW'(KEYWORD_BYTES)) ? seen_reg + KCW'(1) : seen_reg;
        pos_next  = npos;

        case (phase_next)
            PH_SEEK_START: begin
                if (seen_next >= ls && start_hit[ls]) begin
                    found_next = npos;
                    after_next = '0;
                    phase_next = PH_SEEK_END;
                    if (le == '0) begin
                        res_valid  = 1'b1;
                        res_off    = npos;
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_SEEK_END: begin
                span_gap = npos - found_next;
                if (after_next < KCW'(KEYWORD_BYTES)) begin
                    after_next = after_next + KCW'(1);
                end
                if (after_next >= le && end_hit[le]) begin
                    res_valid  = 1'b1;
                    res_off    = found_next;
                    res_len    = (span_gap >= OFFSET_BITS'(le)) ? span_gap - OFFSET_BITS'(le)
                                                                : '0;
                    phase_next = PH_DONE;
                end
            end
            default: ;
        endcase

        if (s_tlast) begin
            if (!res_valid && phase_next == PH_SEEK_START) begin
                res_valid  = 1'b1;
                res_status = ST_START_MISSING;
            end else if (!res_valid && phase_next == PH_SEEK_END) begin
                res_valid  = 1'b1;
                res_status = ST_END_MISSING;
                res_off    = found_next;
            end
            phase_next = PH_SEEK_START;
            found_next = '0;
            after_next = '0;
            seen_next  = '0;
            pos_next   = '0;
        end
    end

    generate
        if (OFFSET_BITS > OUT_FIELD_W) begin : g_clip
            assign res_off_c = (|res_off[OFFSET_BITS-1:OUT_FIELD_W]) ? '1
                                                                      : res_off[OUT_FIELD_W-1:0];
            assign res_len_c = (|res_len[OFFSET_BITS-1:OUT_FIELD_W]) ? '1
                                                                      : res_len[OUT_FIELD_W-1:0];
        end else begin : g_ext
            assign res_off_c = OUT_FIELD_W'(res_off);
            assign res_len_c = OUT_FIELD_W'(res_len);
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pat_reg <= '0;
            start_len_reg <= '0;
            end_pat_reg   <= '0;
            end_len_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_wr_index))
                REG_START_PATTERN: start_pat_reg <= cfg_wr_data;
                REG_START_LENGTH:  start_len_reg <= cfg_wr_data[3:0];
                REG_END_PATTERN:   end_pat_reg   <= cfg_wr_data;
                REG_END_LENGTH:    end_len_reg   <= cfg_wr_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < KEYWORD_BYTES; k++) begin
                win_reg[k] <= '0;
            end
            seen_reg  <= '0;
            after_reg <= '0;
            phase_reg <= PH_SEEK_START;
            pos_reg   <= '0;
            found_reg <= '0;
        end else if (accept) begin
            for (int k = 0; k < KEYWORD_BYTES; k++) begin
                win_reg[k] <= s_tlast ? 8'h00 : win_next[k];
            end
            seen_reg  <= seen_next;
            after_reg <= after_next;
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            out_status_reg <= res_status;
            out_off_reg    <= res_off_c;
            out_len_reg    <= res_len_c;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_len_reg, out_off_reg};

    `ASSERT_CLK(a_missing_start_zero,
        m_tvalid && m_tuser == ST_START_MISSING |-> m_tdata == '0,
        "start-missing result carries non-zero fields")
    `ASSERT_CLK(a_last_clears,
        s_tvalid && s_tready && s_tlast |=> phase_reg == PH_SEEK_START && pos_reg == '0,
        "search state not cleared after last beat")
    `ASSERT_CLK(a_found_behind_pos,
        found_reg <= pos_reg,
        "found offset ahead of stream position")
    `ASSERT_CLK(a_seen_bounded,
        seen_reg <= KCW'(KEYWORD_BYTES) && after_reg <= KCW'(KEYWORD_BYTES),
        "window counters past keyword size")

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for delimited_span_locator: byte streams in, span reports out.
// Depends on dsl_pkg and the design files. A built-in span predictor
// checks every report.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dsl_pkg::*;

    localparam longint unsigned POS_LIMIT = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_beat_t;

    typedef struct {
        status_t     status;
        logic [31:0] offset;
        logic [31:0] length;
    } span_report_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    reg_index_t             cfg_wr_index = REG_START_PATTERN;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;   // data_byte
    logic                   s_tlast = 1'b0; // last_byte
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [63:0]            m_tdata;        // span_offset, span_length
    logic [1:0]             m_tuser;        // status

    stream_beat_t bytes_pending[$];
    span_report_t spans_due[$];
    int           send_idle_pct = 37;
    int           recv_idle_pct = 76;
    int           mismatch_count = 0;

    // keyword registers as last written
    logic [63:0] kw_start = '0;
    logic [63:0] kw_end = '0;
    logic [3:0]  kw_start_len = '0;
    logic [3:0]  kw_end_len = '0;

    // search state of the predictor
    logic [7:0]      win [8];
    int unsigned     win_fill;
    phase_t          phase;
    longint unsigned pos;
    int unsigned     after_start;
    longint unsigned found_off;

    delimited_span_locator u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int unsigned kw_len(logic [3:0] l);
        return (l > 4'd8) ? 8 : int'(l);
    endfunction

    function automatic bit window_hit(logic [63:0] pat, int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            if (win[n - 1 - i] != pat[8*i +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_search();
        foreach (win[i]) win[i] = '0;
        win_fill = 0;
        phase = PH_SEEK_START;
        pos = 0;
        after_start = 0;
        found_off = 0;
    endtask

    task automatic queue_span(status_t st, longint unsigned off, longint unsigned len);
        span_report_t r;
        r.status = st;
        r.offset = (off > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : off[31:0];
        r.length = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
        spans_due.push_back(r);
    endtask

    task automatic predict_span(stream_beat_t b);
        int unsigned     ls;
        int unsigned     le;
        longint unsigned npos;
        longint unsigned span_gap;
        bit              got;
        ls = kw_len(kw_start_len);
        le = kw_len(kw_end_len);
        got = 1'b0;
        if (phase == PH_SEEK_START && ls == 0) begin
            found_off = pos;
            after_start = 0;
            phase = PH_SEEK_END;
        end
        if (phase == PH_SEEK_END && le == 0) begin
            queue_span(ST_FOUND, found_off, 0);
            got = 1'b1;
            phase = PH_DONE;
        end
        for (int i = 7; i > 0; i--) win[i] = win[i-1];
        win[0] = b.data;
        if (win_fill < 8) win_fill++;
        npos = (pos >= POS_LIMIT) ? POS_LIMIT : pos + 1;
        pos = npos;
        if (phase == PH_SEEK_START) begin
            if (win_fill >= ls && window_hit(kw_start, ls)) begin
                found_off = npos;
                after_start = 0;
                phase = PH_SEEK_END;
                if (le == 0) begin
                    queue_span(ST_FOUND, found_off, 0);
                    got = 1'b1;
                    phase = PH_DONE;
                end
            end
        end else if (phase == PH_SEEK_END) begin
            if (after_start < 8) after_start++;
            if (after_start >= le && window_hit(kw_end, le)) begin
                span_gap = npos - found_off;
                queue_span(ST_FOUND, found_off, (span_gap >= le) ? span_gap - le : 0);
                got = 1'b1;
                phase = PH_DONE;
            end
        end
        if (b.last) begin
            if (!got && phase == PH_SEEK_START) queue_span(ST_START_MISSING, 0, 0);
            else if (!got && phase == PH_SEEK_END) queue_span(ST_END_MISSING, found_off, 0);
            clear_search();
        end
    endtask

    task automatic flag_mismatch(string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // driver: holds a beat until taken, random gaps between beats
    always @(posedge aclk) begin
        stream_beat_t nb;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (bytes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nb = bytes_pending.pop_front();
                s_tdata  <= nb.data;
                s_tlast  <= nb.last;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: checks reports, predicts from accepted bytes, stalls the result side
    always @(posedge aclk) begin
        span_report_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (spans_due.size() == 0) begin
                    flag_mismatch($sformatf("report with nothing pending, status %0d", m_tuser));
                end else begin
                    e = spans_due.pop_front();
                    if (m_tuser != e.status)
                        flag_mismatch($sformatf("status %0d, want %0d", m_tuser, e.status));
                    if (m_tdata[31:0] != e.offset)
                        flag_mismatch($sformatf("span_offset %0d, want %0d",
                                                m_tdata[31:0], e.offset));
                    if (m_tdata[63:32] != e.length)
                        flag_mismatch($sformatf("span_length %0d, want %0d",
                                                m_tdata[63:32], e.length));
                end
            end
            if (s_tvalid && s_tready) predict_span('{data: s_tdata, last: s_tlast});
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic set_keywords(logic [63:0] sp, logic [3:0] sl, logic [63:0] ep,
                                logic [3:0] el);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= REG_START_PATTERN;
        cfg_wr_data  <= sp;
        @(posedge aclk);
        cfg_wr_index <= REG_START_LENGTH;
        cfg_wr_data  <= {60'd0, sl};
        @(posedge aclk);
        cfg_wr_index <= REG_END_PATTERN;
        cfg_wr_data  <= ep;
        @(posedge aclk);
        cfg_wr_index <= REG_END_LENGTH;
        cfg_wr_data  <= {60'd0, el};
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        kw_start     = sp;
        kw_start_len = sl;
        kw_end       = ep;
        kw_end_len   = el;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (bytes_pending.size() != 0 || s_tvalid || spans_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic push_beat(logic [7:0] d, logic l);
        bytes_pending.push_back('{data: d, last: l});
    endtask

    function automatic logic [7:0] noise_byte();
        int k;
        k = $urandom_range(7);
        case ($urandom_range(3))
            0, 1: return 8'($urandom_range(255));
            2: return kw_start[8*k +: 8];
            default: return kw_end[8*k +: 8];
        endcase
    endfunction

    function automatic logic [3:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 4'd0;
        if (r < 20) return 4'd8;
        if (r < 28) return 4'($urandom_range(15, 9));
        return 4'($urandom_range(4, 1));
    endfunction

    function automatic logic [63:0] pick_pattern();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    // mostly start..end framed streams; some lack a keyword or are pure noise
    task automatic add_stream();
        logic [7:0]  q[$];
        int          kind;
        int unsigned ls;
        int unsigned le;
        ls = kw_len(kw_start_len);
        le = kw_len(kw_end_len);
        kind = $urandom_range(99);
        repeat ($urandom_range(6)) q.push_back(noise_byte());
        if (kind < 80)
            for (int unsigned i = 0; i < ls; i++) q.push_back(kw_start[8*i +: 8]);
        repeat ($urandom_range(12)) q.push_back(noise_byte());
        if (kind < 70 || (kind >= 80 && kind < 90))
            for (int unsigned i = 0; i < le; i++) q.push_back(kw_end[8*i +: 8]);
        repeat ($urandom_range(4)) q.push_back(noise_byte());
        if (q.size() == 0) q.push_back(noise_byte());
        foreach (q[i]) push_beat(q[i], i == q.size() - 1);
    endtask

    initial begin
        int start_count;
        clear_search();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // both keywords empty: report on first byte, rest ignored
        set_keywords('1, 4'd0, '1, 4'd0);
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b1);
        wait_drained();

        // over-long start keyword cut to eight bytes; then a stream without it
        set_keywords('1, 4'd15, 64'h0, 4'd1);
        repeat (8) push_beat(8'hFF, 1'b0);
        push_beat(8'h05, 1'b0);
        push_beat(8'h00, 1'b1);
        push_beat(8'h11, 1'b0);
        push_beat(8'h22, 1'b0);
        push_beat(8'h33, 1'b1);
        wait_drained();

        // all-zero end keyword must not match the empty window; end missing
        set_keywords(64'h41, 4'd1, 64'h0, 4'd8);
        push_beat(8'h41, 1'b0);
        repeat (2) push_beat(8'h00, 1'b0);
        push_beat(8'h00, 1'b1);
        wait_drained();

        for (int ph = 0; ph < 12; ph++) begin
            send_idle_pct = (ph < 4) ? 37 : (ph < 8) ? 76 : 0;
            recv_idle_pct = (ph < 4) ? 76 : (ph < 8) ? 37 : 0;
            set_keywords(pick_pattern(), pick_len(), pick_pattern(), pick_len());
            start_count = bytes_pending.size();
            while (bytes_pending.size() - start_count < 170) add_stream();
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_top: errors");
        $finish;
    end

endmodule
